// File: sv/rsi_pkg.sv
`default_nettype none

package rsi_pkg;

   localparam int MAX_BASE_DEF = 128;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_CHAR   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_BASE = 2'd1;
   localparam logic [1:0] STATUS_NO_DIGIT = 2'd2;

   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_SIGN,
      PH_DIGIT,
      PH_FROZEN
   } phase_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0]         status;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: sv/rsi_cell.sv
`default_nettype none

module rsi_cell (
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire logic [7:0] prev_sym,
   output logic [7:0]      sym,
   input  wire logic       load,
   input  wire logic       active,
   input  wire logic [7:0] query,
   output logic            hit
);

   logic [7:0] sym_ff;
   logic       hit_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         sym_ff <= prev_sym;
      end
      if (load) begin
         hit_ff <= active && (sym_ff == query);
      end
   end

   assign sym = sym_ff;
   assign hit = hit_ff;

endmodule

`default_nettype wire

// File: sv/radix_string_to_integer.sv
// Channel  Ports                              Direction  Payload
// req      req_valid req_stall req_payload    in         kind, symbol, last
// rsp      rsp_valid rsp_stall rsp_payload    out        value, status
//
// On accept every alphabet cell registers its symbol compare; the parse or
// load step is applied when the block leaves its execute state.
// Symbols enter the cell chain at cell 0 and shift toward the tail on append.
// A result waits in the output register; a further result holds the block
// in its execute state until that register frees. Reset is synchronous and
// clears the alphabet length, the error flag, the parser, the state and rsp valid.
`default_nettype none

module radix_string_to_integer #(
   parameter int MAX_BASE = rsi_pkg::MAX_BASE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire rsi_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsi_pkg::rsp_payload_type      rsp_payload
);

   localparam int POS_W = $clog2(MAX_BASE);
   localparam int CNT_W = $clog2(MAX_BASE + 1);

   rsi_pkg::ctrl_type        state_ff, state_in;
   rsi_pkg::req_payload_type item_ff;
   rsi_pkg::phase_type       phase_ff, phase_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     bad_ff, bad_in;
   logic                     minus_ff, minus_in;
   logic [31:0]              acc_ff, acc_in;
   logic                     seen_ff, seen_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsi_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                     accept;
   logic                     shift;
   logic [MAX_BASE-1:0]      hits;
   logic [7:0]               syms [MAX_BASE];

   assign req_stall = (state_ff != rsi_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   genvar g;
   generate
      for (g = 0; g < MAX_BASE; g++) begin : g_cell
         rsi_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .prev_sym ((g == 0) ? item_ff.symbol : syms[(g == 0) ? 0 : g - 1]),
            .sym      (syms[g]),
            .load     (accept),
            .active   (CNT_W'(g) < count_ff),
            .query    (req_payload.symbol),
            .hit      (hits[g])
         );
      end
   endgenerate

   always_comb begin
      logic             any_hit;
      logic [POS_W-1:0] pos;
      logic [31:0]      digit;
      logic [7:0]       c;
      logic             need_rsp;
      logic             done;
      logic             used;
      rsi_pkg::phase_type ph;
      logic [1:0]       status;

      any_hit = 1'b0;
      pos     = '0;
      for (int p = 0; p < MAX_BASE; p++) begin
         any_hit = any_hit | hits[p];
         pos     = pos | (hits[p] ? POS_W'(p) : '0);
      end
      digit = 32'(count_ff - CNT_W'(1) - CNT_W'(pos));

      c        = item_ff.symbol;
      need_rsp = (item_ff.kind == rsi_pkg::KIND_CHAR) && item_ff.last;
      done     = !need_rsp || !rsp_valid_ff || !rsp_stall;

      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      bad_in         = bad_ff;
      minus_in       = minus_ff;
      acc_in         = acc_ff;
      seen_in        = seen_ff;
      shift          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      used           = 1'b0;
      ph             = phase_ff;
      status         = rsi_pkg::STATUS_OK;

      case (state_ff)
         rsi_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rsi_pkg::ST_EXEC;
            end
         end
         rsi_pkg::ST_EXEC: begin
            if (done) begin
               state_in = rsi_pkg::ST_IDLE;
               case (item_ff.kind)
                  rsi_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     bad_in   = 1'b0;
                  end
                  rsi_pkg::KIND_APPEND: begin
                     if (c == rsi_pkg::CH_PLUS || c == rsi_pkg::CH_MINUS ||
                         c < rsi_pkg::CH_BANG || c > rsi_pkg::CH_TILDE || any_hit ||
                         count_ff >= CNT_W'(MAX_BASE)) begin
                        bad_in = 1'b1;
                     end else begin
                        shift    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  rsi_pkg::KIND_CHAR: begin
                     if (ph == rsi_pkg::PH_SPACE) begin
                        if (c inside {[rsi_pkg::CH_TAB:rsi_pkg::CH_CR], rsi_pkg::CH_SPACE}) begin
                           used = 1'b1;
                        end else begin
                           ph = rsi_pkg::PH_SIGN;
                        end
                     end
                     if (!used && ph == rsi_pkg::PH_SIGN) begin
                        if (c == rsi_pkg::CH_PLUS || c == rsi_pkg::CH_MINUS) begin
                           used = 1'b1;
                           if (c == rsi_pkg::CH_MINUS) begin
                              minus_in = !minus_ff;
                           end
                        end else begin
                           ph = rsi_pkg::PH_DIGIT;
                        end
                     end
                     if (!used && ph == rsi_pkg::PH_DIGIT) begin
                        if (!any_hit) begin
                           ph = rsi_pkg::PH_FROZEN;
                        end else begin
                           acc_in  = 32'(acc_ff * 32'(count_ff)) + digit;
                           seen_in = 1'b1;
                        end
                     end
                     phase_in = ph;
                     if (item_ff.last) begin
                        if (bad_ff || count_ff < CNT_W'(2)) begin
                           status = rsi_pkg::STATUS_BAD_BASE;
                        end else if (!seen_in) begin
                           status = rsi_pkg::STATUS_NO_DIGIT;
                        end
                        rsp_valid_in          = 1'b1;
                        rsp_payload_in.status = status;
                        rsp_payload_in.value  = '0;
                        if (status == rsi_pkg::STATUS_OK) begin
                           rsp_payload_in.value = minus_in ? (32'd0 - acc_in) : acc_in;
                        end
                        phase_in = rsi_pkg::PH_SPACE;
                        minus_in = 1'b0;
                        acc_in   = '0;
                        seen_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = rsi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsi_pkg::ST_IDLE;
         phase_ff     <= rsi_pkg::PH_SPACE;
         count_ff     <= '0;
         bad_ff       <= 1'b0;
         minus_ff     <= 1'b0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         bad_ff       <= bad_in;
         minus_ff     <= minus_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// File: sv/rsi_checker.sv
`default_nettype none

module rsi_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire rsi_pkg::rsp_payload_type rsp_payload
);

   // every accepted transaction keeps the block busy, so req_stall is raised after the accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp transaction changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != rsi_pkg::STATUS_OK |-> rsp_payload.value == 0)
      else $error("nonzero value with error status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == rsi_pkg::STATUS_OK ||
                    rsp_payload.status == rsi_pkg::STATUS_BAD_BASE ||
                    rsp_payload.status == rsi_pkg::STATUS_NO_DIGIT)
      else $error("unknown status code");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind radix_string_to_integer rsi_checker u_rsi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// File: tb/radix_string_to_integer_tb.sv
`timescale 1ns / 1ps

module radix_string_to_integer_tb;

   localparam int         MAX_BASE    = rsi_pkg::MAX_BASE_DEF;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         ITEM_TARGET = 700;

   class conversion_scoreboard;
      logic [7:0]               alphabet [MAX_BASE];
      int unsigned              alphabet_len;
      bit                       alphabet_bad;
      rsi_pkg::phase_type       phase;
      bit                       negative;
      logic [31:0]              acc;
      bit                       have_digit;
      rsi_pkg::rsp_payload_type expected_results[$];
      int unsigned              error_count;

      function new();
         alphabet_len = 0;
         alphabet_bad = 0;
         error_count  = 0;
         clear_parser();
      endfunction

      function void clear_parser();
         phase      = rsi_pkg::PH_SPACE;
         negative   = 0;
         acc        = '0;
         have_digit = 0;
      endfunction

      function int digit_of(logic [7:0] c);
         for (int i = 0; i < alphabet_len; i++) begin
            if (alphabet[i] == c) return i;
         end
         return -1;
      endfunction

      function void parse_char(logic [7:0] c);
         int d;
         if (phase == rsi_pkg::PH_SPACE) begin
            if ((c >= rsi_pkg::CH_TAB && c <= rsi_pkg::CH_CR) || c == rsi_pkg::CH_SPACE) return;
            phase = rsi_pkg::PH_SIGN;
         end
         if (phase == rsi_pkg::PH_SIGN) begin
            if (c == rsi_pkg::CH_PLUS || c == rsi_pkg::CH_MINUS) begin
               if (c == rsi_pkg::CH_MINUS) negative = !negative;
               return;
            end
            phase = rsi_pkg::PH_DIGIT;
         end
         if (phase == rsi_pkg::PH_DIGIT) begin
            d = digit_of(c);
            if (d < 0) begin
               phase = rsi_pkg::PH_FROZEN;
               return;
            end
            acc        = acc * 32'(alphabet_len) + 32'(d);
            have_digit = 1;
         end
      endfunction

      function void note_request(rsi_pkg::req_payload_type t);
         rsi_pkg::rsp_payload_type r;
         case (t.kind)
            rsi_pkg::KIND_CLEAR: begin
               alphabet_len = 0;
               alphabet_bad = 0;
            end
            rsi_pkg::KIND_APPEND: begin
               if (t.symbol == rsi_pkg::CH_PLUS || t.symbol == rsi_pkg::CH_MINUS ||
                   t.symbol < rsi_pkg::CH_BANG || t.symbol > rsi_pkg::CH_TILDE ||
                   digit_of(t.symbol) >= 0 || alphabet_len >= MAX_BASE) begin
                  alphabet_bad = 1;
               end else begin
                  alphabet[alphabet_len] = t.symbol;
                  alphabet_len++;
               end
            end
            rsi_pkg::KIND_CHAR: begin
               parse_char(t.symbol);
               if (t.last) begin
                  if (alphabet_bad || alphabet_len < 2) r.status = rsi_pkg::STATUS_BAD_BASE;
                  else if (!have_digit) r.status = rsi_pkg::STATUS_NO_DIGIT;
                  else r.status = rsi_pkg::STATUS_OK;
                  r.value = '0;
                  if (r.status == rsi_pkg::STATUS_OK) r.value = negative ? (32'd0 - acc) : acc;
                  expected_results.push_back(r);
                  clear_parser();
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsi_pkg::rsp_payload_type got);
         rsi_pkg::rsp_payload_type want;
         if (expected_results.size() == 0) begin
            $error("unexpected transaction: value %0d, status %0d", got.value, got.status);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            error_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   rsi_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsi_pkg::rsp_payload_type rsp_payload;

   conversion_scoreboard sb = new();

   int unsigned burst_left = 0;
   int unsigned item_count = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   radix_string_to_integer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
   end

   task automatic send_item(logic [1:0] kind, logic [7:0] symbol, logic last);
      rsi_pkg::req_payload_type t;
      int unsigned              gap;
      t.kind   = kind;
      t.symbol = symbol;
      t.last   = last;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(t);
      burst_left--;
      if (kind != KIND_UNUSED) item_count++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(rsi_pkg::KIND_CHAR, s[i], i == s.len() - 1);
      end
   endtask

   task automatic send_alphabet(string s);
      send_item(rsi_pkg::KIND_CLEAR, 8'h00, 1'b0);
      for (int i = 0; i < s.len(); i++) begin
         send_item(rsi_pkg::KIND_APPEND, s[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] random_space();
      int unsigned r;
      r = $urandom_range(0, 5);
      return (r == 5) ? rsi_pkg::CH_SPACE : 8'(rsi_pkg::CH_TAB + r);
   endfunction

   function automatic logic [7:0] random_digit();
      if (sb.alphabet_len == 0) return 8'($urandom_range(rsi_pkg::CH_BANG, rsi_pkg::CH_TILDE));
      return sb.alphabet[$urandom_range(0, sb.alphabet_len - 1)];
   endfunction

   task automatic send_bad_append();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0: c = rsi_pkg::CH_PLUS;
         1: c = rsi_pkg::CH_MINUS;
         2: c = 8'($urandom_range(0, 32));
         3: c = 8'($urandom_range(127, 255));
         default: c = (sb.alphabet_len > 0) ? random_digit() : rsi_pkg::CH_PLUS;
      endcase
      send_item(rsi_pkg::KIND_APPEND, c, 1'($urandom_range(0, 1)));
   endtask

   task automatic random_alphabet();
      logic [7:0]  pool[$];
      int unsigned size;
      int unsigned idx;
      int unsigned bad_at;
      for (int c = rsi_pkg::CH_BANG; c <= rsi_pkg::CH_TILDE; c++) begin
         if (c != rsi_pkg::CH_PLUS && c != rsi_pkg::CH_MINUS) pool.push_back(8'(c));
      end
      case ($urandom_range(0, 9))
         0: size = pool.size();
         1: size = $urandom_range(0, 1);
         2: size = $urandom_range(11, 91);
         default: size = $urandom_range(2, 10);
      endcase
      bad_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, size) : size + 1;
      send_item(rsi_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (int i = 0; i <= size; i++) begin
         if (i == bad_at) send_bad_append();
         if (i < size) begin
            idx = $urandom_range(0, pool.size() - 1);
            send_item(rsi_pkg::KIND_APPEND, pool[idx], 1'($urandom_range(0, 1)));
            pool.delete(idx);
         end
      end
   endtask

   task automatic random_string();
      logic [7:0]  text[$];
      int unsigned n;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n) text.push_back(random_space());
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
      repeat (n) text.push_back($urandom_range(0, 1) ? rsi_pkg::CH_MINUS : rsi_pkg::CH_PLUS);
      case ($urandom_range(0, 9))
         0: n = 0;
         1: n = $urandom_range(9, 24);
         default: n = $urandom_range(1, 8);
      endcase
      repeat (n) text.push_back(random_digit());
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0 && text.size() > 0) begin
         text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if (text.size() == 0) text.push_back(random_space());
      foreach (text[i]) begin
         if ($urandom_range(0, 29) == 0) begin
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 39) == 0) begin
            send_item(rsi_pkg::KIND_APPEND,
                      8'($urandom_range(rsi_pkg::CH_BANG, rsi_pkg::CH_TILDE)), 1'b0);
         end
         send_item(rsi_pkg::KIND_CHAR, text[i], i == text.size() - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("7");
      send_alphabet("01");
      send_text("\t\n\v\f\r +-+-1101");
      send_text("+-");
      send_text("10x1");
      send_item(rsi_pkg::KIND_CHAR, 8'h31, 1'b0);
      send_item(rsi_pkg::KIND_CHAR, 8'h00, 1'b0);
      send_text("1");
      send_item(KIND_UNUSED, 8'hFF, 1'b1);
      send_item(rsi_pkg::KIND_APPEND, rsi_pkg::CH_PLUS, 1'b1);
      send_text("1");
      send_alphabet("01");
      send_item(rsi_pkg::KIND_CHAR, 8'h31, 1'b0);
      send_item(rsi_pkg::KIND_APPEND, 8'h32, 1'b0);
      send_text("2");

      while (item_count < ITEM_TARGET) begin
         if ($urandom_range(0, 15) == 0 || sb.alphabet_len < 2) random_alphabet();
         else random_string();
      end
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/rsi_pkg.sv
sv/rsi_cell.sv
sv/radix_string_to_integer.sv
sv/rsi_checker.sv
tb/radix_string_to_integer_tb.sv
